>>> rtl/rde_pkg.sv
// Shared constants for the reversible deque engine: store depth, derived widths,
// operation codes and the controller state type. Depends on nothing.
package rde_pkg;

    localparam int DEPTH       = 32;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;
    localparam int COUNT_OUT_W = 6;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 2'd1;
    localparam logic [OP_W-1:0] OP_REM_HEAD = 2'd2;
    localparam logic [OP_W-1:0] OP_REVERSE  = 2'd3;

    typedef enum logic
    {
        ST_IDLE,
        ST_READ
    } rde_state_t;

endpackage

>>> rtl/rde_if.sv
// Valid/ready channel interfaces for the request and result streams of the
// reversible deque engine. Depends on rde_pkg.
interface rde_req_if;
    import rde_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] in_value;

    modport source (output valid, output op, output in_value, input ready);
    modport sink   (input valid, input op, input in_value, output ready);
endinterface

interface rde_rsp_if;
    import rde_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_OUT_W-1:0] element_count;

    modport source (output valid, output ok, output removed_value, output element_count,
                    input ready);
    modport sink   (input valid, input ok, input removed_value, input element_count,
                    output ready);
endinterface

>>> rtl/reversible_deque_engine.sv
// Top level of the reversible deque engine: ring pointers, direction flag and
// result register around one slot RAM. Depends on rde_pkg, rde_if and rde_ram.
//
//  Channel  Modport      Payload                                 Transfer
//  req      rde_req_if   op, in_value                            valid && ready
//  rsp      rde_rsp_if   ok, removed_value, element_count        valid && ready
//
// Inserts, reverses and failed removals load the result register directly; a
// successful removal waits in ST_READ for the slot RAM's registered read data.
// A request is taken only when the result register is empty or being emptied.
// Reset empties the queue and clears the direction flag; the RAM needs no clearing.
// A stalled result holds its payload until the transfer completes.
module reversible_deque_engine (
    input  logic           clk,
    input  logic           rst_n,
    rde_req_if.sink        req,
    rde_rsp_if.source      rsp
);
    import rde_pkg::*;

    rde_state_t state_reg, state_next;

    logic [PTR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rev_reg, rev_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic               fire, load_read, out_free;
    logic               full, empty, at_front, start_read;
    logic [PTR_W-1:0]   front_inc, front_dec, back_addr, tail_addr;
    logic [SUM_W-1:0]   sum, sum_m1;

    logic               ram_we, ram_re;
    logic [PTR_W-1:0]   ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    rde_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.in_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = req.valid && req.ready;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        empty     = (count_reg == '0);
        at_front  = (req.op == OP_INS_HEAD) ^ rev_reg;
        front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);
        front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
        sum       = SUM_W'(front_reg) + SUM_W'(count_reg);
        sum_m1    = sum - SUM_W'(1);
        back_addr = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);
        tail_addr = (sum_m1 >= SUM_W'(DEPTH)) ? PTR_W'(sum_m1 - SUM_W'(DEPTH))
                                              : PTR_W'(sum_m1);
    end

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        ram_we      = 1'b0;
        ram_waddr   = back_addr;
        ram_re      = 1'b0;
        ram_raddr   = front_reg;
        start_read  = 1'b0;
        out_ok_next = 1'b0;
        if (fire)
        begin
            case (req.op)
                OP_INS_HEAD, OP_INS_TAIL:
                begin
                    if (!full)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = at_front ? front_dec : back_addr;
                        front_next  = at_front ? front_dec : front_reg;
                        count_next  = count_reg + CNT_W'(1);
                        out_ok_next = 1'b1;
                    end
                end
                OP_REM_HEAD:
                begin
                    if (!empty)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = rev_reg ? tail_addr : front_reg;
                        front_next = rev_reg ? front_reg : front_inc;
                        count_next = count_reg - CNT_W'(1);
                        start_read = 1'b1;
                    end
                end
                default:
                begin
                    rev_next    = !rev_reg;
                    out_ok_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        load_read = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = out_free;
            end
            ST_READ:
            begin
                load_read = 1'b1;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        if (load_read)
        begin
            out_valid_next = 1'b1;
            out_value_next = ram_rdata;
            out_count_next = COUNT_OUT_W'(count_reg);
        end
        else if (fire && !start_read)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            out_count_next = COUNT_OUT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_read)
        begin
            out_ok_reg <= 1'b1;
        end
        else if (fire && !start_read)
        begin
            out_ok_reg <= out_ok_next;
        end
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = out_ok_reg;
    assign rsp.removed_value = out_value_reg;
    assign rsp.element_count = out_count_reg;

endmodule

>>> rtl/rde_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/rde_checker.sv
// Port-level assertions for the reversible deque engine and the bind that
// attaches them to the top level. Depends on rde_pkg and reversible_deque_engine.
module rde_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic                                rsp_ok,
    input logic [rde_pkg::VALUE_W-1:0]         rsp_removed_value,
    input logic [rde_pkg::COUNT_OUT_W-1:0]     rsp_element_count
);
    import rde_pkg::*;

    // A result that waits keeps its whole payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
            && $stable(rsp_removed_value) && $stable(rsp_element_count))
        else $error("result changed while stalled");

    // A request is only taken when the result register can take its result.
    a_req_room: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("request taken while a result was blocked");

    // A failed operation never reports a removed value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_removed_value == '0)
        else $error("failed operation reported a value");

    // The reported count never exceeds the capacity of the store.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_element_count <= COUNT_OUT_W'(DEPTH))
        else $error("element count above capacity");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_ok            (rsp.ok),
    .rsp_removed_value (rsp.removed_value),
    .rsp_element_count (rsp.element_count)
);
